>>> sv/nca_pkg.sv
// ----------------------------------------------------------------------------
// nca_pkg: shared types and constants for the nearest centre assignment block
// Holds the sizes, operation and register codes, the request and result
// payload types, and the structs passed between the top level and its cells.
// ----------------------------------------------------------------------------
package nca_pkg;

    // Sizes of the centre table and the element format.
    localparam int NUM_CENTERS      = 64;
    localparam int MAX_DIM          = 64;
    localparam int VALUE_BITS       = 16;

    // Fixed field widths of the interface.
    localparam int CENTER_IDX_BITS  = 6;
    localparam int ELEMENT_IDX_BITS = 6;
    localparam int DATA_BITS        = 16;
    localparam int REG_BITS         = 7;
    localparam int SUM_BITS         = 38;
    localparam int CFG_INDEX_BITS   = 1;

    // Derived widths.
    localparam int ADDR_BITS = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ABS_BITS  = VALUE_BITS + 1;
    localparam int SQ_BITS   = 2 * ABS_BITS;
    localparam int ACC_BITS  = ((SQ_BITS > SUM_BITS) ? SQ_BITS : SUM_BITS) + 1;

    // Saturation limit of a running distance sum.
    localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

    // Operation codes.
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_FEATURE = 1'b1;

    // Register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_ACTIVE_DIM     = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ACTIVE_CENTERS = 1'b1;

    // Register reset values.
    localparam logic [REG_BITS-1:0] ACTIVE_DIM_RESET     = 7'd64;
    localparam logic [REG_BITS-1:0] ACTIVE_CENTERS_RESET = 7'd64;

    // Request payload.
    typedef struct packed {
        logic                        op;
        logic [CENTER_IDX_BITS-1:0]  center_index;
        logic [ELEMENT_IDX_BITS-1:0] element_index;
        logic signed [DATA_BITS-1:0] value;
    } in_item_t;

    // Result payload.
    typedef struct packed {
        logic [CENTER_IDX_BITS-1:0] nearest_center;
        logic [SUM_BITS-1:0]        nearest_distance;
    } out_item_t;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic                         wr_en;
        logic [CENTER_IDX_BITS-1:0]   wr_center;
        logic [ADDR_BITS-1:0]         addr;
        logic signed [VALUE_BITS-1:0] wr_data;
        logic                         rd_en;
        logic signed [VALUE_BITS-1:0] feature;
        logic                         sq_en;
        logic                         acc_en;
        logic                         clear;
        logic [REG_BITS-1:0]          ncent;
    } cell_ctrl_t;

    // Running minimum handed from one cell to the next during the search.
    typedef struct packed {
        logic                       valid;
        logic [CENTER_IDX_BITS-1:0] idx;
        logic [SUM_BITS-1:0]        sum;
    } chain_t;

endpackage

>>> sv/nearest_center_assign_top.sv
// ----------------------------------------------------------------------------
// nearest_center_assign_top: nearest cluster centre by squared distance
// Sequencer, configuration registers and result register around a row of
// centre cells.
// ----------------------------------------------------------------------------
// A load request writes one centre element. A feature request passes through
// the registered read of every cell's centre store, the square of the
// difference, and the accumulation into each cell's distance sum, all cells
// working in parallel. The request that closes a vector then starts a running
// minimum down the row of NUM_CENTERS cells, one cell per cycle, so it occupies
// the block until the search reaches the end of the row and its result is
// handed over, plus any time the previous result is still waiting to be taken.
// Sums saturate at the largest value the distance field can carry; on a tie
// the lowest centre index wins. Centre elements must be loaded before they
// take part in a distance.
module nearest_center_assign_top
    import nca_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [REG_BITS-1:0]       cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  in_item_t                  in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output out_item_t                 out_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_ACC   = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_PUT   = 3'd5;

    logic [2:0]                   state_reg;
    logic [2:0]                   state_next;
    logic [REG_BITS-1:0]          active_dim_reg;
    logic [REG_BITS-1:0]          active_centers_reg;
    logic [REG_BITS-1:0]          count_reg;
    logic [REG_BITS-1:0]          count_next;
    logic signed [VALUE_BITS-1:0] x_reg;
    logic                         last_reg;
    logic                         last_next;
    logic                         out_valid_reg;
    out_item_t                    out_data_reg;
    out_item_t                    pend_reg;
    logic [REG_BITS-1:0]          dim_eff;
    logic [REG_BITS-1:0]          ncent_eff;
    logic [REG_BITS-1:0]          pos;
    logic                         in_accept;
    logic                         put_fire;
    cell_ctrl_t                   ctrl;
    chain_t                       chain_w [NUM_CENTERS+1];
    logic [NUM_CENTERS-1:0]       chain_valids;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_dim_reg     <= ACTIVE_DIM_RESET;
            active_centers_reg <= ACTIVE_CENTERS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ACTIVE_DIM:     active_dim_reg     <= cfg_data;
                REG_ACTIVE_CENTERS: active_centers_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Registers outside their range act as the nearest legal value.
    always_comb
    begin
        if (active_dim_reg == '0)
            dim_eff = REG_BITS'(1);
        else if (active_dim_reg > REG_BITS'(MAX_DIM))
            dim_eff = REG_BITS'(MAX_DIM);
        else
            dim_eff = active_dim_reg;

        if (active_centers_reg == '0)
            ncent_eff = REG_BITS'(1);
        else if (active_centers_reg > REG_BITS'(NUM_CENTERS))
            ncent_eff = REG_BITS'(NUM_CENTERS);
        else
            ncent_eff = active_centers_reg;
    end

    // Element position of the incoming feature and end-of-vector detection.
    assign pos = (count_reg >= REG_BITS'(MAX_DIM)) ? REG_BITS'(MAX_DIM - 1) : count_reg;
    assign last_next = (REG_BITS'(pos + REG_BITS'(1)) >= dim_eff);

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign put_fire  = (state_reg == S_PUT) && (!out_valid_reg || !out_stall);

    // Control broadcast to the cells.
    always_comb
    begin
        ctrl.wr_en     = in_accept && (in_data.op == OP_LOAD)
                         && (32'(in_data.element_index) < MAX_DIM)
                         && (32'(in_data.center_index) < NUM_CENTERS);
        ctrl.wr_center = in_data.center_index;
        ctrl.addr      = (in_data.op == OP_LOAD) ? in_data.element_index[ADDR_BITS-1:0]
                                                 : pos[ADDR_BITS-1:0];
        ctrl.wr_data   = in_data.value[VALUE_BITS-1:0];
        ctrl.rd_en     = in_accept && (in_data.op == OP_FEATURE);
        ctrl.feature   = x_reg;
        ctrl.sq_en     = (state_reg == S_MUL);
        ctrl.acc_en    = (state_reg == S_ACC);
        ctrl.clear     = put_fire;
        ctrl.ncent     = ncent_eff;
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (in_data.op == OP_FEATURE))
                begin
                    state_next = S_MUL;
                    count_next = last_next ? '0 : REG_BITS'(count_reg + REG_BITS'(1));
                end
            end
            S_MUL:   state_next = S_ACC;
            S_ACC:   state_next = last_reg ? S_START : S_IDLE;
            S_START: state_next = S_WAIT;
            S_WAIT:
            begin
                if (chain_w[NUM_CENTERS].valid)
                    state_next = S_PUT;
            end
            S_PUT:
            begin
                if (put_fire)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (in_accept)
                last_reg <= last_next;
        end
    end

    // Feature value and pending result.
    always_ff @(posedge clk)
    begin
        if (in_accept)
            x_reg <= in_data.value[VALUE_BITS-1:0];
        if ((state_reg == S_WAIT) && chain_w[NUM_CENTERS].valid)
        begin
            pend_reg.nearest_center   <= chain_w[NUM_CENTERS].idx;
            pend_reg.nearest_distance <= chain_w[NUM_CENTERS].sum;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (put_fire)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (put_fire)
            out_data_reg <= pend_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Row of centre cells; the running minimum enters at the first cell.
    always_comb
    begin
        chain_w[0].valid = (state_reg == S_START);
        chain_w[0].idx   = '0;
        chain_w[0].sum   = SUM_MAX;
    end

    for (genvar i = 0; i < NUM_CENTERS; i++)
    begin : g_cell
        nca_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_id   (CENTER_IDX_BITS'(i)),
            .ctrl      (ctrl),
            .chain_in  (chain_w[i]),
            .chain_out (chain_w[i+1])
        );
        assign chain_valids[i] = chain_w[i+1].valid;
    end

`ifndef ASSERT_OFF
    // Only one running minimum travels along the row at a time.
    a_one_search: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(chain_valids))
        else $error("more than one search token in the cell row");

    // The end of the row is reached only while the sequencer waits for it.
    a_tail_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        chain_w[NUM_CENTERS].valid |-> (state_reg == S_WAIT))
        else $error("search result arrived outside the wait state");

    // A new result appears only from the hand-over state.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_PUT))
        else $error("result raised without a finished search");

    // The element counter never passes the largest vector length.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= REG_BITS'(MAX_DIM))
        else $error("element counter out of range");
`endif

endmodule

>>> sv/nca_cell.sv
// ----------------------------------------------------------------------------
// nca_cell: one centre of the nearest centre search
// Stores the elements of one centre, squares the difference to each feature
// element, keeps the saturating distance sum, and takes part in the running
// minimum that travels along the row of cells.
// ----------------------------------------------------------------------------
module nca_cell
    import nca_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [CENTER_IDX_BITS-1:0] cell_id,
    input  cell_ctrl_t                 ctrl,
    input  chain_t                     chain_in,
    output chain_t                     chain_out
);

    logic signed [VALUE_BITS-1:0] mem [MAX_DIM];
    logic signed [VALUE_BITS-1:0] rd_data_reg;
    logic        [SQ_BITS-1:0]    sq_reg;
    logic        [SQ_BITS-1:0]    sq_next;
    logic        [SUM_BITS-1:0]   sum_reg;
    logic        [SUM_BITS-1:0]   sum_next;
    logic signed [ABS_BITS-1:0]   diff;
    logic        [ABS_BITS-1:0]   abs_diff;
    logic        [ACC_BITS-1:0]   acc;
    logic                         active;
    logic                         wr_hit;
    chain_t                       chain_reg;
    chain_t                       chain_next;

    // A cell takes part only while its index is below the active centre count.
    assign active = ({1'b0, cell_id} < ctrl.ncent);
    assign wr_hit = ctrl.wr_en && (ctrl.wr_center == cell_id);

    // Centre element store with a registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            mem[ctrl.addr] <= ctrl.wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[ctrl.addr];
        end
    end

    // Exact difference, its magnitude and its square.
    always_comb
    begin
        diff     = ABS_BITS'(ctrl.feature) - ABS_BITS'(rd_data_reg);
        abs_diff = diff[ABS_BITS-1] ? ABS_BITS'(-diff) : ABS_BITS'(diff);
        sq_next  = SQ_BITS'(abs_diff) * SQ_BITS'(abs_diff);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sq_en)
        begin
            sq_reg <= sq_next;
        end
    end

    // Saturating accumulation of the squared difference.
    always_comb
    begin
        acc      = ACC_BITS'(sum_reg) + ACC_BITS'(sq_reg);
        sum_next = sum_reg;
        if (ctrl.clear)
        begin
            sum_next = '0;
        end
        else if (ctrl.acc_en && active)
        begin
            sum_next = (acc > ACC_BITS'(SUM_MAX)) ? SUM_MAX : acc[SUM_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    // Running minimum: a strictly smaller sum replaces it, so ties keep the
    // lower index that arrived from upstream.
    always_comb
    begin
        chain_next = chain_in;
        if (chain_in.valid && active && (sum_reg < chain_in.sum))
        begin
            chain_next.idx = cell_id;
            chain_next.sum = sum_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= '0;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    assign chain_out = chain_reg;

endmodule

>>> tb/sv/nearest_center_assign_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_center_assign_top_tb: self-checking bench for the nearest centre block
// Loads the centre table, streams feature vectors under several register
// settings and idle patterns, and checks every assignment against a local
// bit-exact predictor of the squared distances and the nearest search.
// ----------------------------------------------------------------------------
module nearest_center_assign_top_tb;
    import nca_pkg::*;

    localparam logic signed [DATA_BITS-1:0] VALUE_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};
    localparam logic signed [DATA_BITS-1:0] VALUE_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};
    localparam longint unsigned SUM_LIMIT = SUM_MAX;
    // The closing request runs the search down every cell, so allow that and a margin.
    localparam int SETTLE_CYCLES = NUM_CENTERS + 16;
    localparam int STUCK_LIMIT   = 4000;
    // Centres below FULL_ROWS are loaded in full; every other centre has only its
    // first HEAD_COLS elements loaded. Register choices keep all reads inside that.
    localparam int FULL_ROWS     = 4;
    localparam int HEAD_COLS     = 4;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [REG_BITS-1:0]       cfg_data = '0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    // Idle and stall rates, in cycles of a hundred.
    int send_idle_pct = 0;
    int stall_pct = 0;

    // Predictor state.
    logic signed [VALUE_BITS-1:0] centre_table [NUM_CENTERS][MAX_DIM];
    longint unsigned              centre_sums [NUM_CENTERS];
    logic [REG_BITS-1:0]          elem_pos;
    logic [REG_BITS-1:0]          dim_reg;
    logic [REG_BITS-1:0]          centres_reg;
    out_item_t                    nearest_due [$];

    int errors = 0;
    int n_loads = 0;
    int n_features = 0;
    int n_results = 0;
    int n_settings = 0;
    int stuck_cycles = 0;

    nearest_center_assign_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // A register value of zero acts as one, and values above the size act as the size.
    function automatic int active_count(input logic [REG_BITS-1:0] r, input int hi);
        if (r == 0)
            return 1;
        if (r > hi)
            return hi;
        return r;
    endfunction

    function automatic logic signed [DATA_BITS-1:0] rand_value();
        case ($urandom_range(7))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2: return DATA_BITS'(int'($urandom_range(2)) - 1);
            default: return DATA_BITS'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Apply one request to the predictor; a closing feature element queues an assignment.
    task automatic accumulate_distances(input in_item_t req);
        logic signed [VALUE_BITS-1:0] x;
        longint          diff;
        longint unsigned sq;
        longint unsigned best_sum;
        int              pos;
        int              ndim;
        int              ncent;
        int              best;
        int              c;
        out_item_t       res;
        x = req.value[VALUE_BITS-1:0];
        ndim = active_count(dim_reg, MAX_DIM);
        ncent = active_count(centres_reg, NUM_CENTERS);
        if (req.op == OP_LOAD)
        begin
            n_loads++;
            if (req.center_index < NUM_CENTERS && req.element_index < MAX_DIM)
                centre_table[req.center_index][req.element_index] = x;
            return;
        end
        n_features++;
        pos = (elem_pos >= MAX_DIM) ? MAX_DIM - 1 : elem_pos;
        for (c = 0; c < ncent; c++)
        begin
            diff = longint'(x) - longint'(centre_table[c][pos]);
            sq = diff * diff;
            if (sq > SUM_LIMIT || centre_sums[c] > SUM_LIMIT - sq)
                centre_sums[c] = SUM_LIMIT;
            else
                centre_sums[c] += sq;
        end
        elem_pos = elem_pos + 1'b1;
        if (pos + 1 < ndim)
            return;
        // Strict comparison keeps the lowest index on a tie.
        best = 0;
        best_sum = centre_sums[0];
        for (c = 1; c < ncent; c++)
        begin
            if (centre_sums[c] < best_sum)
            begin
                best_sum = centre_sums[c];
                best = c;
            end
        end
        res.nearest_center = best[CENTER_IDX_BITS-1:0];
        res.nearest_distance = best_sum[SUM_BITS-1:0];
        nearest_due.push_back(res);
        for (c = 0; c < NUM_CENTERS; c++)
            centre_sums[c] = 0;
        elem_pos = '0;
    endtask

    // Send one request, idling first at the current rate; valid stays high on return.
    task automatic send_request(input in_item_t req);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        accumulate_distances(req);
    endtask

    task automatic load_element(input logic [CENTER_IDX_BITS-1:0] ci,
                                input logic [ELEMENT_IDX_BITS-1:0] ei,
                                input logic signed [DATA_BITS-1:0] v);
        in_item_t req;
        req.op = OP_LOAD;
        req.center_index = ci;
        req.element_index = ei;
        req.value = v;
        send_request(req);
    endtask

    // Index fields carry random content on feature requests; the block ignores them.
    task automatic stream_element(input logic signed [DATA_BITS-1:0] v);
        in_item_t req;
        req.op = OP_FEATURE;
        req.center_index = CENTER_IDX_BITS'($urandom());
        req.element_index = ELEMENT_IDX_BITS'($urandom());
        req.value = v;
        send_request(req);
    endtask

    // Wait until every assignment has arrived and any partial accumulation has drained.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (nearest_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_registers(input logic [REG_BITS-1:0] dim,
                                 input logic [REG_BITS-1:0] centres);
        settle_block();
        cfg_write <= 1'b1;
        cfg_index <= REG_ACTIVE_DIM;
        cfg_data <= dim;
        @(posedge clk);
        cfg_index <= REG_ACTIVE_CENTERS;
        cfg_data <= centres;
        @(posedge clk);
        cfg_write <= 1'b0;
        dim_reg = dim;
        centres_reg = centres;
        n_settings++;
    endtask

    // Write a single register, leaving the other one as it is; the block must be idle.
    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [REG_BITS-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == REG_ACTIVE_DIM)
            dim_reg = val;
        else
            centres_reg = val;
    endtask

    // Load the table, then run vectors with one register still at its reset value.
    task automatic test_reset_defaults();
        for (int c = 0; c < NUM_CENTERS; c++)
            for (int e = 0; e < MAX_DIM; e++)
                if (c < FULL_ROWS || e < HEAD_COLS)
                    load_element(CENTER_IDX_BITS'(c), ELEMENT_IDX_BITS'(e), rand_value());
        // The centre count is still at its reset value, so the search covers every cell.
        settle_block();
        write_register(REG_ACTIVE_DIM, REG_BITS'(HEAD_COLS));
        repeat (4 * HEAD_COLS) stream_element(rand_value());
        // Then full-length vectors over the completely loaded centres.
        settle_block();
        write_register(REG_ACTIVE_CENTERS, REG_BITS'(FULL_ROWS));
        write_register(REG_ACTIVE_DIM, REG_BITS'(MAX_DIM));
        repeat (MAX_DIM) stream_element(rand_value());
    endtask

    // Extreme values: zero distance, mirrored extremes and the largest possible sum.
    task automatic test_value_extremes();
        set_registers(2, 2);
        load_element(0, 0, VALUE_MIN);
        load_element(0, 1, VALUE_MAX);
        load_element(1, 0, VALUE_MAX);
        load_element(1, 1, VALUE_MIN);
        stream_element(VALUE_MAX);
        stream_element(VALUE_MIN);
        stream_element(VALUE_MIN);
        stream_element(VALUE_MAX);
        set_registers(REG_BITS'(MAX_DIM), 1);
        for (int e = 0; e < MAX_DIM; e++)
            load_element(0, ELEMENT_IDX_BITS'(e), VALUE_MIN);
        repeat (MAX_DIM) stream_element(VALUE_MAX);
    endtask

    task automatic test_tie_lowest_index();
        set_registers(1, 4);
        load_element(0, 0, 100);
        load_element(1, 0, 5);
        load_element(2, 0, 5);
        load_element(3, 0, 5);
        stream_element(5);
        stream_element(50);
        load_element(0, 0, 5);
        stream_element(7);
    endtask

    // Zero acts as one and anything above the size acts as the size.
    task automatic test_register_clamp();
        set_registers(7'd127, 7'd0);
        repeat (MAX_DIM) stream_element(rand_value());
        set_registers(7'd0, 7'd127);
        repeat (2) stream_element(rand_value());
    endtask

    // Sums gathered so far survive a register change in the middle of a vector.
    task automatic test_change_mid_vector();
        set_registers(8, 3);
        repeat (5) stream_element(rand_value());
        set_registers(3, 3);
        stream_element(rand_value());
        set_registers(4, 2);
        repeat (2) stream_element(rand_value());
        set_registers(4, 6);
        repeat (2) stream_element(rand_value());
    endtask

    task automatic test_load_mid_vector();
        set_registers(4, 2);
        repeat (2) stream_element(rand_value());
        load_element(0, 2, rand_value());
        load_element(1, 3, rand_value());
        repeat (2) stream_element(rand_value());
    endtask

    function automatic logic [REG_BITS-1:0] pick_register();
        case ($urandom_range(15))
            0: return REG_BITS'(0);
            1: return REG_BITS'(1);
            2: return REG_BITS'(64);
            3: return REG_BITS'($urandom_range(65, 127));
            4: return REG_BITS'($urandom_range(1, 64));
            default: return REG_BITS'($urandom_range(1, 8));
        endcase
    endfunction

    // Mostly complete vectors with random content, some cut short, with stray loads between.
    task automatic test_random_traffic(input int target);
        int start;
        int elems;
        logic [REG_BITS-1:0] dim;
        logic [REG_BITS-1:0] centres;
        start = n_loads + n_features;
        while (n_loads + n_features - start < target)
        begin
            dim = pick_register();
            centres = pick_register();
            // Positions beyond the loaded head are only read from fully loaded centres.
            if ((active_count(dim, MAX_DIM) > HEAD_COLS || elem_pos >= HEAD_COLS)
                && active_count(centres, NUM_CENTERS) > FULL_ROWS)
                centres = REG_BITS'($urandom_range(FULL_ROWS));
            set_registers(dim, centres);
            repeat ($urandom_range(1, 4))
            begin
                elems = active_count(dim_reg, MAX_DIM);
                if ($urandom_range(7) == 0)
                    elems = $urandom_range(elems);
                repeat (elems)
                begin
                    if ($urandom_range(9) == 0)
                        load_element(CENTER_IDX_BITS'($urandom()),
                                     ELEMENT_IDX_BITS'($urandom()), rand_value());
                    stream_element(rand_value());
                end
            end
        end
    endtask

    // Receiver stall pattern.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Compare every accepted result with the oldest pending assignment.
    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (nearest_due.size() == 0)
            begin
                report_mismatch("unexpected result, nearest_center", out_data.nearest_center, 0);
            end
            else
            begin
                want = nearest_due.pop_front();
                if (out_data.nearest_center !== want.nearest_center)
                    report_mismatch("nearest_center", out_data.nearest_center,
                                    want.nearest_center);
                if (out_data.nearest_distance !== want.nearest_distance)
                    report_mismatch("nearest_distance", out_data.nearest_distance,
                                    want.nearest_distance);
            end
        end
    end

    // Watchdog on cycles in which no request and no result is accepted.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles == STUCK_LIMIT)
        begin
            $display("Timeout: no progress for %0d cycles", STUCK_LIMIT);
            $display("** nearest_center_assign_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        dim_reg = ACTIVE_DIM_RESET;
        centres_reg = ACTIVE_CENTERS_RESET;
        elem_pos = '0;
        for (int c = 0; c < NUM_CENTERS; c++)
            centre_sums[c] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 25;
        stall_pct = 79;
        test_reset_defaults();
        test_value_extremes();
        test_tie_lowest_index();
        test_register_clamp();
        test_change_mid_vector();
        test_load_mid_vector();
        test_random_traffic(350);

        send_idle_pct = 79;
        stall_pct = 25;
        test_random_traffic(350);

        send_idle_pct = 0;
        stall_pct = 0;
        test_random_traffic(350);

        settle_block();
        $display("Sent %0d centre loads and %0d feature elements; checked %0d assignments.",
                 n_loads, n_features, n_results);
        $display("Used %0d register settings under three sender and receiver idle patterns.",
                 n_settings);
        if (errors == 0)
            $display("** nearest_center_assign_top: PASSED **");
        else
            $display("** nearest_center_assign_top: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
sv/nca_pkg.sv
sv/nca_cell.sv
sv/nearest_center_assign_top.sv
tb/sv/nearest_center_assign_top_tb.sv
